// ----- rtl/pol_pkg.sv -----
`default_nettype none
package pol_pkg;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_APPEND     = 3'd0;
  localparam logic [2:0] MODE_INSERT     = 3'd1;
  localparam logic [2:0] MODE_REMOVE_POS = 3'd2;
  localparam logic [2:0] MODE_REMOVE_VAL = 3'd3;
  localparam logic [2:0] MODE_REPLACE    = 3'd4;
  localparam logic [2:0] MODE_READ       = 3'd5;
  localparam logic [2:0] MODE_FIND       = 3'd6;

  // Found index reported when nothing matched
  localparam logic [3:0] IDX_NONE = 4'hF;

  typedef struct packed {
    logic [2:0]         mode;
    logic [3:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] data_out;
    logic signed [3:0]  found_index;
    logic [3:0]         entry_count;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/positional_ordered_list.sv -----
// Channel   Ports                      Handshake
// input     in_item                    taken when start=1 and busy=0
// result    out_item                   shown for one cycle with out_strobe=1
//
// Each item is registered first and then executed across all cells in
// parallel; busy is high for the execute cycle only.
// The result appears the cycle after execute, while the next item may be taken.
// Reset (rst_n low, synchronous) empties the list; stored cells are not cleared.
// The receiver cannot stall: results are always taken on their strobe cycle.
`default_nettype none
module positional_ordered_list #(
  parameter int CAPACITY = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pol_pkg::in_item_t in_item,
  output logic                   out_strobe,
  output pol_pkg::out_item_t     out_item
);

  pol_pkg::dp_cmd_t cmd;

  // Sequencer
  pol_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // Cells, search and result logic
  pol_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

// ----- rtl/pol_ctrl.sv -----
`default_nettype none
module pol_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output logic                  out_strobe,
  output pol_pkg::dp_cmd_t      cmd
);

  pol_pkg::state_t state_r;
  pol_pkg::state_t state_nxt;
  logic            strobe_r;
  logic            strobe_nxt;

  // Next state: take an item in idle, then execute it and return to idle
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pol_pkg::ST_IDLE: begin
        if (start) state_nxt = pol_pkg::ST_EXEC;
      end
      pol_pkg::ST_EXEC: begin
        state_nxt = pol_pkg::ST_IDLE;
      end
      default: state_nxt = pol_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state_r)
      pol_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      pol_pkg::ST_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  // Result strobe follows the execute cycle, in step with the output register
  assign strobe_nxt = cmd.exec;
  assign out_strobe = strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pol_pkg::ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pol_dp.sv -----
`default_nettype none
module pol_dp #(
  parameter int CAPACITY = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pol_pkg::dp_cmd_t  cmd,
  input  wire pol_pkg::in_item_t in_item,
  output pol_pkg::out_item_t     out_item
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > 4) ? CW : 4;

  pol_pkg::in_item_t  item_r;
  pol_pkg::out_item_t out_r;
  pol_pkg::out_item_t out_nxt;
  logic [31:0]        cells_r   [CAPACITY];
  logic [31:0]        cells_nxt [CAPACITY];
  logic [31:0]        up_src    [CAPACITY];
  logic [31:0]        dn_src    [CAPACITY];
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;

  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      cnt_x;
  logic [XW-1:0]      tgt_x;
  logic [IW-1:0]      tgt_i;
  logic [CAPACITY-1:0] match;
  logic               hit;
  logic [IW-1:0]      hit_idx;
  logic               full;
  logic               in_range;
  logic               do_ins;
  logic               do_del;
  logic               do_rep;

  assign pos_x    = XW'(item_r.position);
  assign cnt_x    = XW'(count_r);
  assign full     = (cnt_x == XW'(CAPACITY));
  assign in_range = (pos_x < cnt_x);

  // Sources for shifting up (insert) and down (remove)
  for (genvar g = 0; g < CAPACITY; g++) begin : g_src
    if (g == 0) begin : g_first
      assign up_src[g] = item_r.value;
    end else begin : g_rest
      assign up_src[g] = cells_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign dn_src[g] = cells_r[g];
    end else begin : g_lower
      assign dn_src[g] = cells_r[g+1];
    end
  end

  // Compare every live cell against the value at once
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (XW'(i) < cnt_x) && (cells_r[i] == item_r.value);
    end
  end

  // First matching position: lowest index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  // Decode operation and target cell
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    do_rep = 1'b0;
    tgt_x  = pos_x;
    case (item_r.mode)
      pol_pkg::MODE_APPEND: begin
        tgt_x  = cnt_x;
        do_ins = !full;
      end
      pol_pkg::MODE_INSERT: begin
        do_ins = !full && (pos_x <= cnt_x);
      end
      pol_pkg::MODE_REMOVE_POS: begin
        do_del = in_range;
      end
      pol_pkg::MODE_REMOVE_VAL: begin
        tgt_x  = XW'(hit_idx);
        do_del = hit;
      end
      pol_pkg::MODE_REPLACE: begin
        do_rep = in_range;
      end
      default: tgt_x = pos_x;
    endcase
  end

  assign tgt_i = tgt_x[IW-1:0];

  // Cell update: shift up, shift down or overwrite one cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (XW'(i) > tgt_x)       cells_nxt[i] = up_src[i];
        else if (XW'(i) == tgt_x) cells_nxt[i] = item_r.value;
      end else if (do_del) begin
        if (XW'(i) >= tgt_x)      cells_nxt[i] = dn_src[i];
      end else if (do_rep) begin
        if (XW'(i) == tgt_x)      cells_nxt[i] = item_r.value;
      end
    end
  end

  // Count and result
  always_comb begin
    count_nxt           = count_r;
    if (do_ins) count_nxt = count_r + CW'(1);
    else if (do_del) count_nxt = count_r - CW'(1);

    out_nxt.ok          = 1'b0;
    out_nxt.data_out    = '0;
    out_nxt.found_index = pol_pkg::IDX_NONE;
    case (item_r.mode)
      pol_pkg::MODE_APPEND, pol_pkg::MODE_INSERT: begin
        out_nxt.ok = do_ins;
      end
      pol_pkg::MODE_REMOVE_POS, pol_pkg::MODE_REMOVE_VAL: begin
        out_nxt.ok = do_del;
        if (do_del) out_nxt.data_out = cells_r[tgt_i];
      end
      pol_pkg::MODE_REPLACE: begin
        out_nxt.ok = do_rep;
      end
      pol_pkg::MODE_READ: begin
        out_nxt.ok = in_range;
        if (in_range) out_nxt.data_out = cells_r[tgt_i];
      end
      pol_pkg::MODE_FIND: begin
        out_nxt.ok = hit;
        if (hit) out_nxt.found_index = 4'(hit_idx);
      end
      default: out_nxt.ok = 1'b0;
    endcase
    out_nxt.entry_count = 4'(count_nxt);
  end

  assign out_item = out_r;

  // Item and result registers, storage cells
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.exec) begin
      out_r <= out_nxt;
      for (int i = 0; i < CAPACITY; i++) cells_r[i] <= cells_nxt[i];
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pol_checker.sv -----
`default_nettype none
module pol_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire pol_pkg::out_item_t out_item
);

  // An accepted item makes the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A result strobe follows every accepted item
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result missing two cycles after accept");

  // No result without an item before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without an item in execution");

  // A reported index means a successful find
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.found_index != pol_pkg::IDX_NONE) |-> out_item.ok)
    else $error("found index without success");

  // Reset leaves the block idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("not idle after reset");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int CAPACITY = 8;
  localparam int ITEM_TOTAL = 1300;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    pol_pkg::in_item_t  cmd;
    bit                 typed;
    pol_pkg::out_item_t want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  pol_pkg::in_item_t  in_item;
  logic               out_strobe;
  pol_pkg::out_item_t out_item;

  // shadow copy of the list
  logic signed [31:0] list_vals [CAPACITY];
  int                 list_len;
  int                 peak_len;

  pol_pkg::out_item_t pending_results [$];
  stim_row_t          stim_rows [$];

  int  mismatches;
  int  results_seen;
  int  ok_results;
  int  cycle_cnt = 0;
  int  mode_items [8];
  bit  no_idle;

  positional_ordered_list #(.CAPACITY(CAPACITY)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Work out the result of one operation and update the shadow list
  function automatic pol_pkg::out_item_t list_op_result(input pol_pkg::in_item_t it);
    pol_pkg::out_item_t r;
    int                 p;
    int                 at;
    int                 i;
    r.ok          = 1'b0;
    r.data_out    = '0;
    r.found_index = pol_pkg::IDX_NONE;
    p  = int'(it.position);
    at = -1;
    // first match within the valid entries
    for (i = list_len - 1; i >= 0; i--)
      if (list_vals[i] == it.value) at = i;
    case (it.mode)
      pol_pkg::MODE_APPEND, pol_pkg::MODE_INSERT: begin
        if (it.mode == pol_pkg::MODE_APPEND) p = list_len;
        if (list_len < CAPACITY && p <= list_len) begin
          for (i = list_len; i > p; i--) list_vals[i] = list_vals[i - 1];
          list_vals[p] = it.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      pol_pkg::MODE_REMOVE_POS, pol_pkg::MODE_REMOVE_VAL: begin
        if (it.mode == pol_pkg::MODE_REMOVE_VAL) p = at;
        if (p >= 0 && p < list_len) begin
          r.data_out = list_vals[p];
          for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      pol_pkg::MODE_REPLACE: begin
        if (p < list_len) begin
          list_vals[p] = it.value;
          r.ok = 1'b1;
        end
      end
      pol_pkg::MODE_READ: begin
        if (p < list_len) begin
          r.data_out = list_vals[p];
          r.ok = 1'b1;
        end
      end
      pol_pkg::MODE_FIND: begin
        if (at >= 0) begin
          r.found_index = 4'(at);
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = 4'(list_len);
    if (list_len > peak_len) peak_len = list_len;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] mode, input logic [3:0] pos,
                                  input logic signed [31:0] val, input bit typed,
                                  input logic ok, input logic signed [31:0] data,
                                  input logic [3:0] cnt);
    stim_row_t row;
    row.cmd.mode              = mode;
    row.cmd.position          = pos;
    row.cmd.value             = val;
    row.typed                 = typed;
    row.want.ok               = ok;
    row.want.data_out         = data;
    row.want.found_index      = pol_pkg::IDX_NONE;
    row.want.entry_count      = cnt;
    stim_rows.push_back(row);
  endfunction

  // Present one item, wait for it to be taken, then log its expected result.
  // Called at a rising edge; returns at the edge that took the item.
  task automatic drive_item(input pol_pkg::in_item_t it, input bit typed,
                            input pol_pkg::out_item_t want, input bit pause);
    int                 gap;
    pol_pkg::out_item_t calc;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0 || pause) start <= 1'b0;
    // hold off until every outstanding result is back
    if (pause) begin
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
    end
    repeat (gap) @(posedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    calc = list_op_result(it);
    pending_results.push_back(typed ? want : calc);
    mode_items[it.mode]++;
  endtask

  // Random item biased towards the current contents of the list
  function automatic pol_pkg::in_item_t pick_item(input bit grow);
    pol_pkg::in_item_t it;
    int                r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if      (r < 25) it.mode = pol_pkg::MODE_APPEND;
      else if (r < 48) it.mode = pol_pkg::MODE_INSERT;
      else if (r < 55) it.mode = pol_pkg::MODE_REMOVE_POS;
      else if (r < 61) it.mode = pol_pkg::MODE_REMOVE_VAL;
      else if (r < 72) it.mode = pol_pkg::MODE_REPLACE;
      else if (r < 84) it.mode = pol_pkg::MODE_READ;
      else if (r < 97) it.mode = pol_pkg::MODE_FIND;
      else             it.mode = MODE_UNUSED;
    end else begin
      if      (r < 8)  it.mode = pol_pkg::MODE_APPEND;
      else if (r < 15) it.mode = pol_pkg::MODE_INSERT;
      else if (r < 38) it.mode = pol_pkg::MODE_REMOVE_POS;
      else if (r < 58) it.mode = pol_pkg::MODE_REMOVE_VAL;
      else if (r < 69) it.mode = pol_pkg::MODE_REPLACE;
      else if (r < 81) it.mode = pol_pkg::MODE_READ;
      else if (r < 97) it.mode = pol_pkg::MODE_FIND;
      else             it.mode = MODE_UNUSED;
    end
    if ($urandom_range(0, 9) < 7) it.position = 4'($urandom_range(0, list_len));
    else                          it.position = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 40 && list_len > 0) begin
      it.value = list_vals[$urandom_range(0, list_len - 1)];
    end else if (r < 55) begin
      case ($urandom_range(0, 4))
        0:       it.value = VAL_MIN;
        1:       it.value = VAL_MAX;
        2:       it.value = -32'sd1;
        3:       it.value = 32'sd1;
        default: it.value = '0;
      endcase
    end else begin
      it.value = $urandom;
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    pol_pkg::out_item_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result %p", out_item));
      end else begin
        want = pending_results.pop_front();
        if (want.ok) ok_results++;
        if (out_item.ok !== want.ok)
          note_mismatch($sformatf("ok got %b want %b", out_item.ok, want.ok));
        if (out_item.data_out !== want.data_out)
          note_mismatch($sformatf("data_out got %h want %h", out_item.data_out,
                                  want.data_out));
        if (out_item.found_index !== want.found_index)
          note_mismatch($sformatf("found_index got %0d want %0d", out_item.found_index,
                                  want.found_index));
        if (out_item.entry_count !== want.entry_count)
          note_mismatch($sformatf("entry_count got %0d want %0d", out_item.entry_count,
                                  want.entry_count));
      end
    end
  end

  // stimulus
  initial begin
    pol_pkg::out_item_t no_want;
    pol_pkg::in_item_t  it;
    bit                 grow;
    int                 n;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    list_len    = 0;
    peak_len    = 0;
    mismatches  = 0;
    results_seen = 0;
    ok_results  = 0;
    no_idle     = 1'b0;
    no_want     = '0;
    foreach (mode_items[k]) mode_items[k] = 0;
    foreach (list_vals[k]) list_vals[k] = '0;

    // empty list, then fill to capacity, overflow, edit and drain a little
    add_row(pol_pkg::MODE_READ,       4'd0,  32'sd0,        1, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_REMOVE_POS, 4'd0,  32'sd0,        1, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_REMOVE_VAL, 4'd0,  32'sd0,        1, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_FIND,       4'd0,  32'sd0,        1, 1'b0, 32'sd0, 4'd0);
    add_row(MODE_UNUSED,              4'd15, -32'sd1,       1, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_INSERT,     4'd1,  32'sd5,        1, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_APPEND,     4'd0,  VAL_MIN,       1, 1'b1, 32'sd0, 4'd1);
    add_row(pol_pkg::MODE_INSERT,     4'd0,  VAL_MAX,       1, 1'b1, 32'sd0, 4'd2);
    add_row(pol_pkg::MODE_INSERT,     4'd2,  -32'sd1,       1, 1'b1, 32'sd0, 4'd3);
    add_row(pol_pkg::MODE_APPEND,     4'd15, 32'sd0,        1, 1'b1, 32'sd0, 4'd4);
    add_row(pol_pkg::MODE_INSERT,     4'd4,  32'sd1,        1, 1'b1, 32'sd0, 4'd5);
    add_row(pol_pkg::MODE_APPEND,     4'd0,  32'h5555_5555, 1, 1'b1, 32'sd0, 4'd6);
    add_row(pol_pkg::MODE_APPEND,     4'd0,  -32'sd1,       1, 1'b1, 32'sd0, 4'd7);
    add_row(pol_pkg::MODE_APPEND,     4'd0,  32'sd2,        1, 1'b1, 32'sd0, 4'd8);
    add_row(pol_pkg::MODE_APPEND,     4'd0,  32'sd3,        1, 1'b0, 32'sd0, 4'd8);
    add_row(pol_pkg::MODE_INSERT,     4'd0,  32'sd3,        1, 1'b0, 32'sd0, 4'd8);
    add_row(pol_pkg::MODE_READ,       4'd15, 32'sd0,        1, 1'b0, 32'sd0, 4'd8);
    add_row(pol_pkg::MODE_READ,       4'd7,  32'sd0,        0, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_REPLACE,    4'd8,  32'sd9,        1, 1'b0, 32'sd0, 4'd8);
    add_row(pol_pkg::MODE_REPLACE,    4'd3,  32'hAAAA_AAAA, 0, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_FIND,       4'd0,  -32'sd1,       0, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_FIND,       4'd0,  32'sd12345,    1, 1'b0, 32'sd0, 4'd8);
    add_row(pol_pkg::MODE_REMOVE_VAL, 4'd0,  VAL_MAX,       1, 1'b1, VAL_MAX, 4'd7);
    add_row(pol_pkg::MODE_REMOVE_POS, 4'd0,  32'sd0,        0, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_REMOVE_VAL, 4'd0,  -32'sd1,       0, 1'b0, 32'sd0, 4'd0);
    add_row(pol_pkg::MODE_REMOVE_POS, 4'd15, 32'sd0,        1, 1'b0, 32'sd0, 4'd5);
    add_row(MODE_UNUSED,              4'd0,  32'sd0,        1, 1'b0, 32'sd0, 4'd5);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[k])
      drive_item(stim_rows[k].cmd, stim_rows[k].typed, stim_rows[k].want, 1'b0);

    // random part: alternating fill and drain phases, bursts without idling
    grow = 1'b1;
    for (n = stim_rows.size(); n < ITEM_TOTAL; n++) begin
      if (n % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 0) grow = ~grow;
      end
      it = pick_item(grow);
      drive_item(it, 1'b0, no_want,
                 (n == stim_rows.size()) || ($urandom_range(0, 149) == 0));
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("items: append %0d insert %0d rm_pos %0d rm_val %0d replace %0d",
             mode_items[pol_pkg::MODE_APPEND], mode_items[pol_pkg::MODE_INSERT],
             mode_items[pol_pkg::MODE_REMOVE_POS], mode_items[pol_pkg::MODE_REMOVE_VAL],
             mode_items[pol_pkg::MODE_REPLACE]);
    $display("read %0d find %0d unused %0d; %0d results (%0d ok), peak length %0d",
             mode_items[pol_pkg::MODE_READ], mode_items[pol_pkg::MODE_FIND],
             mode_items[MODE_UNUSED], results_seen, ok_results, peak_len);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- positional_ordered_list.f -----
rtl/pol_pkg.sv
rtl/pol_ctrl.sv
rtl/pol_dp.sv
rtl/positional_ordered_list.sv
rtl/pol_checker.sv
sim/tb.sv
